### hdl/tpa_pkg.sv
package tpa_pkg;

  localparam int FIELD_BITS = 16;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

  localparam logic [1:0] MODE_LIST = 2'd0;
  localparam logic [1:0] MODE_FAN = 2'd1;
  localparam logic [1:0] MODE_STRIP = 2'd2;
  localparam logic [1:0] MODE_OTHER = 2'd3;

  typedef enum logic [2:0] {
    OP_KEEP_ANCHOR,
    OP_KEEP_OLDER,
    OP_KEEP_NEWER,
    OP_LIST_TRI,
    OP_FAN_TRI,
    OP_STRIP_EVEN,
    OP_STRIP_ODD
  } op_t;

  localparam int OP_BITS = $bits(op_t);

  typedef struct packed {
    logic [1:0]                   prim_mode;
    logic                         starts_primitive;
    logic signed [FIELD_BITS-1:0] vert_x;
    logic signed [FIELD_BITS-1:0] vert_y;
  } vertex_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] corner_a_x;
    logic signed [FIELD_BITS-1:0] corner_a_y;
    logic signed [FIELD_BITS-1:0] corner_b_x;
    logic signed [FIELD_BITS-1:0] corner_b_y;
    logic signed [FIELD_BITS-1:0] corner_c_x;
    logic signed [FIELD_BITS-1:0] corner_c_y;
  } triangle_t;

endpackage

### hdl/tpa_front.sv
module tpa_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    vertex_valid,
  output logic                    vertex_stall,
  input  tpa_pkg::vertex_t        vertex,
  input  logic                    q_full,
  output logic                    q_push,
  output tpa_pkg::op_t            q_op,
  output logic [COORD_BITS-1:0]   q_x,
  output logic [COORD_BITS-1:0]   q_y
);
  import tpa_pkg::*;

  localparam int KEEP = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;

  logic [1:0] active_mode, active_mode_next;
  logic [1:0] seen_count, seen_count_next;
  logic       strip_odd, strip_odd_next;
  logic [1:0] mode_eff;
  logic [1:0] cnt_eff;
  logic       odd_eff;
  logic       accept;
  logic       emit;

  assign vertex_stall = q_full;
  assign accept = vertex_valid && !q_full;
  assign q_x = COORD_BITS'(vertex.vert_x[KEEP-1:0]);
  assign q_y = COORD_BITS'(vertex.vert_y[KEEP-1:0]);
  assign q_push = accept && emit;

  // a start beat latches its mode and clears history before it is classified
  always_comb begin
    mode_eff = vertex.starts_primitive ? vertex.prim_mode : active_mode;
    cnt_eff = vertex.starts_primitive ? 2'd0 : seen_count;
    odd_eff = vertex.starts_primitive ? 1'b0 : strip_odd;
    active_mode_next = mode_eff;
    seen_count_next = cnt_eff;
    strip_odd_next = odd_eff;
    emit = 1'b0;
    q_op = OP_KEEP_OLDER;
    if (mode_eff != MODE_OTHER) begin
      emit = 1'b1;
      if (cnt_eff == 2'd0) begin
        q_op = (mode_eff == MODE_FAN) ? OP_KEEP_ANCHOR : OP_KEEP_OLDER;
        seen_count_next = 2'd1;
      end else if (cnt_eff == 2'd1) begin
        q_op = OP_KEEP_NEWER;
        seen_count_next = 2'd2;
      end else begin
        unique case (mode_eff)
          MODE_LIST: begin
            q_op = OP_LIST_TRI;
            seen_count_next = 2'd0;
          end
          MODE_FAN: begin
            q_op = OP_FAN_TRI;
          end
          default: begin
            q_op = odd_eff ? OP_STRIP_ODD : OP_STRIP_EVEN;
            strip_odd_next = !odd_eff;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mode <= MODE_OTHER;
      seen_count <= 2'd0;
      strip_odd <= 1'b0;
    end else if (accept) begin
      active_mode <= active_mode_next;
      seen_count <= seen_count_next;
      strip_odd <= strip_odd_next;
    end
  end

endmodule

### hdl/tpa_queue.sv
module tpa_queue #(
  parameter int WIDTH = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rd_data
);
  import tpa_pkg::*;

  logic [WIDTH-1:0]      entry [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_PTR_BITS:0]   count;

  assign full = (count == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/tpa_back.sv
module tpa_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  tpa_pkg::op_t          q_op,
  input  logic [COORD_BITS-1:0] q_x,
  input  logic [COORD_BITS-1:0] q_y,
  output logic                  q_pop,
  output logic                  triangle_valid,
  input  logic                  triangle_stall,
  output tpa_pkg::triangle_t    triangle
);
  import tpa_pkg::*;

  localparam int KEEP = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;

  logic [COORD_BITS-1:0] anchor_x, anchor_y;
  logic [COORD_BITS-1:0] older_x, older_y;
  logic [COORD_BITS-1:0] newer_x, newer_y;
  logic                  is_tri;
  triangle_t             tri_next;

  function automatic logic [FIELD_BITS-1:0] to_field(input logic [COORD_BITS-1:0] c);
    return FIELD_BITS'(c[KEEP-1:0]);
  endfunction

  assign is_tri = (q_op == OP_LIST_TRI) || (q_op == OP_FAN_TRI) ||
                  (q_op == OP_STRIP_EVEN) || (q_op == OP_STRIP_ODD);
  // history-only beats never wait on the output register
  assign q_pop = q_valid && (!is_tri || !triangle_valid || !triangle_stall);

  always_comb begin
    tri_next.corner_c_x = to_field(q_x);
    tri_next.corner_c_y = to_field(q_y);
    tri_next.corner_a_x = to_field(older_x);
    tri_next.corner_a_y = to_field(older_y);
    tri_next.corner_b_x = to_field(newer_x);
    tri_next.corner_b_y = to_field(newer_y);
    case (q_op)
      OP_FAN_TRI: begin
        tri_next.corner_a_x = to_field(anchor_x);
        tri_next.corner_a_y = to_field(anchor_y);
      end
      OP_STRIP_ODD: begin
        tri_next.corner_a_x = to_field(newer_x);
        tri_next.corner_a_y = to_field(newer_y);
        tri_next.corner_b_x = to_field(older_x);
        tri_next.corner_b_y = to_field(older_y);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      unique case (q_op)
        OP_KEEP_ANCHOR: begin
          anchor_x <= q_x;
          anchor_y <= q_y;
        end
        OP_KEEP_OLDER: begin
          older_x <= q_x;
          older_y <= q_y;
        end
        OP_KEEP_NEWER, OP_FAN_TRI: begin
          newer_x <= q_x;
          newer_y <= q_y;
        end
        OP_STRIP_EVEN, OP_STRIP_ODD: begin
          older_x <= newer_x;
          older_y <= newer_y;
          newer_x <= q_x;
          newer_y <= q_y;
        end
        default: begin
        end
      endcase
    end
    if (q_pop && is_tri) begin
      triangle <= tri_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      triangle_valid <= 1'b0;
    end else if (q_pop && is_tri) begin
      triangle_valid <= 1'b1;
    end else if (!triangle_stall) begin
      triangle_valid <= 1'b0;
    end
  end

endmodule

### hdl/triangle_primitive_assembler.sv
// channel    dir  valid            stall            beat
// vertex     in   vertex_valid     vertex_stall     tpa_pkg::vertex_t
// triangle   out  triangle_valid   triangle_stall   tpa_pkg::triangle_t
//
// one vertex per cycle while vertex_stall is low; a last vertex is queued, then its
// triangle is registered; the front classifies each vertex against mode and count,
// the back holds the corner registers; a two-entry command queue sits between them
// vertex_stall rises only when the queue is full, i.e. the output register is held
// rst is synchronous; control state clears, corner registers are not reset
module triangle_primitive_assembler #(
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vertex_valid,
  output logic               vertex_stall,
  input  tpa_pkg::vertex_t   vertex,
  output logic               triangle_valid,
  input  logic               triangle_stall,
  output tpa_pkg::triangle_t triangle
);
  import tpa_pkg::*;

  localparam int QW = OP_BITS + 2 * COORD_BITS;

  logic                  q_full, q_push, q_pop, q_not_empty;
  op_t                   f_op;
  logic [COORD_BITS-1:0] f_x, f_y;
  logic [QW-1:0]         q_rd;
  op_t                   b_op;

  tpa_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_op         (f_op),
    .q_x          (f_x),
    .q_y          (f_y)
  );

  tpa_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   ({f_op, f_x, f_y}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_data   (q_rd)
  );

  assign b_op = op_t'(q_rd[QW-1 -: OP_BITS]);

  tpa_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_not_empty),
    .q_op           (b_op),
    .q_x            (q_rd[2*COORD_BITS-1:COORD_BITS]),
    .q_y            (q_rd[COORD_BITS-1:0]),
    .q_pop          (q_pop),
    .triangle_valid (triangle_valid),
    .triangle_stall (triangle_stall),
    .triangle       (triangle)
  );

endmodule

### hdl/tpa_checker.sv
module tpa_checker (
  input logic               clk,
  input logic               rst,
  input logic               vertex_valid,
  input logic               vertex_stall,
  input logic               triangle_valid,
  input logic               triangle_stall,
  input tpa_pkg::triangle_t triangle
);
  import tpa_pkg::*;

  // a triangle needs three vertices plus the queue hop
  a_no_early_tri: assert property (@(posedge clk)
    (!rst && ($past(rst) || $past(rst, 2) || $past(rst, 3))) |-> !triangle_valid)
    else $error("triangle too soon after reset");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!triangle_valid && !vertex_stall))
    else $error("reset did not clear handshake");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(vertex_stall) |-> $past(vertex_valid && !vertex_stall))
    else $error("vertex_stall rose without a vertex beat");

  a_tri_hold: assert property (@(posedge clk) disable iff (rst)
    (triangle_valid && triangle_stall) |=> (triangle_valid && $stable(triangle)))
    else $error("stalled triangle changed");

endmodule

bind triangle_primitive_assembler tpa_checker u_tpa_checker (.*);
